[src/mdi_pkg.sv]
package mdi_pkg;

    localparam logic       KIND_LOAD   = 1'b0;
    localparam logic       KIND_QUERY  = 1'b1;

    localparam logic       CFG_YEAR    = 1'b0;
    localparam logic       CFG_BASE1   = 1'b1;

    localparam logic [4:0] MID_DAY     = 5'd15;
    localparam logic [3:0] FIRST_MONTH = 4'd0;
    localparam logic [3:0] LAST_MONTH  = 4'd11;
    localparam logic [3:0] MONTHS      = 4'd12;

    // A year is a multiple of 25 exactly when its product with the inverse of 25
    // modulo 2^16 does not exceed 65535 / 25.
    localparam logic [15:0] INV25      = 16'd23593;
    localparam logic [15:0] MUL25_LIMIT = 16'd2621;

    typedef struct packed {
        logic busy;
        logic done;
    } mdi_div_stat_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1:
                begin
                    len = leap ? 5'd29 : 5'd28;
                end
                4'd3, 4'd5, 4'd8, 4'd10:
                begin
                    len = 5'd30;
                end
                default:
                begin
                    len = 5'd31;
                end
            endcase
            return len;
        end
    endfunction

endpackage

[src/mdi_div.sv]
module mdi_div
    import mdi_pkg::*;
#(
    parameter int DW = 37
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [4:0]    divisor,
    output mdi_div_stat_t stat,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] dvd_next;
    logic [4:0]    rem_reg;
    logic [4:0]    rem_next;
    logic [4:0]    dsr_reg;
    logic [4:0]    dsr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [5:0]    trial;
    logic          fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = 5'd0;
            dsr_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], fits};
            rem_next = fits ? 5'(trial - {1'b0, dsr_reg}) : trial[4:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

[src/monthly_to_daily_interpolator.sv]
// Monthly-to-daily linear interpolator.
// The input channel (in_valid, in_stall) carries load and query items. A load
// writes one of twelve mid-month values and gives no result; a load to a
// month above December is dropped. A query turns a day of the year into a
// daily value, its month and its day of the month, interpolated between
// the two nearest mid-month values.
// After a query is accepted, the calendar is walked one month per step, the
// current and the partner mid-month values are read, their difference is
// multiplied by the day offset, and the serial divide by the month length,
// one quotient bit per cycle, scales it down before the result is saturated.
// One item is worked on at a time; in_stall is high from a query's
// acceptance until its result has been moved into the output register.
// The output channel (out_valid, out_stall) is fed from that register, so a
// new item is taken while an earlier result still waits. If the receiver
// stalls and the register is full, the next result waits inside the block.
// Configuration writes (cfg_valid, cfg_ready) are always taken and set the
// calendar year and the base of the day index. Reset selects the year 2000
// with days counted from one and empties the output register; the value table
// holds nothing defined until it is loaded.
module monthly_to_daily_interpolator
    import mdi_pkg::*;
#(
    parameter int VALUE_BITS    = 32,
    parameter int MAX_DAY_INDEX = 366
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [3:0]            month_index,
    input  logic [VALUE_BITS-1:0] monthly_value,
    input  logic [8:0]            day_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] daily_value,
    output logic [3:0]            month_of_day,
    output logic [5:0]            day_of_month
);

    localparam int VB = VALUE_BITS;
    localparam int DW = VB + 5;
    localparam int PW = VB + 6;
    localparam int SW = VB + 2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SRCH   = 3'd1;
    localparam logic [2:0] ST_RD_CUR = 3'd2;
    localparam logic [2:0] ST_RD_OTH = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DIVS   = 3'd5;
    localparam logic [2:0] ST_DIVW   = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    localparam logic signed [SW-1:0] VMAX = SW'({1'b0, {(VB-1){1'b1}}});
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    logic [VB-1:0] mem [12];
    logic [VB-1:0] rd_data_reg;
    logic [3:0]    rd_addr;
    logic          mem_we;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic          leap_reg;
    logic          leap_next;
    logic          base1_reg;
    logic          base1_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [8:0]    doy_reg;
    logic [8:0]    doy_next;
    logic [3:0]    mon_reg;
    logic [3:0]    mon_next;
    logic [8:0]    cum_reg;
    logic [8:0]    cum_next;
    logic [8:0]    cum_prev_reg;
    logic [8:0]    cum_prev_next;
    logic [5:0]    mday_reg;
    logic [5:0]    mday_next;
    logic [3:0]    partner_reg;
    logic [3:0]    partner_next;
    logic [4:0]    n_reg;
    logic [4:0]    n_next;
    logic [4:0]    k_reg;
    logic [4:0]    k_next;
    logic [VB-1:0] cur_reg;
    logic [VB-1:0] cur_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic          neg_reg;
    logic          neg_next;
    logic [VB-1:0] res_reg;
    logic [VB-1:0] res_next;
    logic [3:0]    res_mon_reg;
    logic [3:0]    res_mon_next;
    logic [5:0]    res_mday_reg;
    logic [5:0]    res_mday_next;

    logic          in_accept;
    logic          out_free;
    logic [9:0]    doy_raw;
    logic [9:0]    doy_clamp;
    logic [15:0]   year_mul;
    logic          div4;
    logic          div16;
    logic          div25;
    logic [8:0]    mday_wide;
    logic [5:0]    mday_cur;
    logic [3:0]    mon_inc;
    logic [3:0]    mon_dec;
    logic signed [PW-1:0] oth_ext;
    logic signed [PW-1:0] cur_ext;
    logic signed [PW-1:0] k_ext;
    logic [PW-1:0] prod_mag;
    logic          div_start;
    mdi_div_stat_t div_stat;
    logic [DW-1:0] quotient;
    logic signed [SW-1:0] q_s;
    logic signed [SW-1:0] sum;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mem_we    = in_accept && (kind == KIND_LOAD) && (month_index < MONTHS);
    assign rd_addr   = (state_reg == ST_RD_CUR) ? mon_reg : partner_reg;
    assign div_start = (state_reg == ST_DIVS);

    assign year_mul = 16'(cfg_data * INV25);
    assign div4     = (cfg_data[1:0] == 2'd0);
    assign div16    = (cfg_data[3:0] == 4'd0);
    assign div25    = (year_mul <= MUL25_LIMIT);

    assign doy_raw   = {1'b0, day_index} + {9'd0, ~base1_reg};
    assign doy_clamp = (doy_raw == 10'd0) ? 10'd1 :
                       (doy_raw > 10'(MAX_DAY_INDEX)) ? 10'(MAX_DAY_INDEX) : doy_raw;

    assign mday_wide = doy_reg - cum_prev_reg;
    assign mday_cur  = mday_wide[5:0];
    assign mon_inc   = (mon_reg == LAST_MONTH) ? FIRST_MONTH : mon_reg + 4'd1;
    assign mon_dec   = (mon_reg == FIRST_MONTH) ? LAST_MONTH : mon_reg - 4'd1;

    assign oth_ext   = PW'($signed(rd_data_reg));
    assign cur_ext   = PW'($signed(cur_reg));
    assign k_ext     = $signed({{(PW-5){1'b0}}, k_reg});
    assign prod_mag  = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);

    assign q_s = neg_reg ? -$signed({2'b00, quotient[VB-1:0]})
                         :  $signed({2'b00, quotient[VB-1:0]});
    assign sum = SW'($signed(cur_reg)) + q_s;

    always_comb
    begin
        state_next     = state_reg;
        leap_next      = leap_reg;
        base1_next     = base1_reg;
        out_valid_next = out_valid_reg;
        doy_next       = doy_reg;
        mon_next       = mon_reg;
        cum_next       = cum_reg;
        cum_prev_next  = cum_prev_reg;
        mday_next      = mday_reg;
        partner_next   = partner_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        res_mon_next   = res_mon_reg;
        res_mday_next  = res_mday_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_YEAR:
                begin
                    leap_next = div4 && (!div25 || div16);
                end
                CFG_BASE1:
                begin
                    base1_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (kind == KIND_QUERY))
                begin
                    doy_next      = doy_clamp[8:0];
                    mon_next      = FIRST_MONTH;
                    cum_prev_next = 9'd0;
                    cum_next      = {4'd0, month_len(FIRST_MONTH, leap_reg)};
                    state_next    = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if ((mon_reg != LAST_MONTH) && (doy_reg > cum_reg))
                begin
                    mon_next      = mon_reg + 4'd1;
                    cum_prev_next = cum_reg;
                    cum_next      = cum_reg + {4'd0, month_len(mon_reg + 4'd1, leap_reg)};
                end
                else
                begin
                    mday_next = mday_cur;
                    if (mday_cur > {1'b0, MID_DAY})
                    begin
                        partner_next = mon_inc;
                        n_next       = month_len(mon_reg, leap_reg);
                        k_next       = 5'(mday_cur - {1'b0, MID_DAY});
                    end
                    else if (mday_cur < {1'b0, MID_DAY})
                    begin
                        partner_next = mon_dec;
                        n_next       = month_len(mon_dec, leap_reg);
                        k_next       = 5'({1'b0, MID_DAY} - mday_cur);
                    end
                    else
                    begin
                        partner_next = mon_reg;
                        n_next       = month_len(mon_reg, leap_reg);
                        k_next       = 5'd0;
                    end
                    state_next = ST_RD_CUR;
                end
            end
            ST_RD_CUR:
            begin
                state_next = ST_RD_OTH;
            end
            ST_RD_OTH:
            begin
                cur_next   = rd_data_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = (oth_ext - cur_ext) * k_ext;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                neg_next   = prod_reg[PW-1];
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (sum > VMAX)
                    begin
                        res_next = VMAX[VB-1:0];
                    end
                    else if (sum < VMIN)
                    begin
                        res_next = VMIN[VB-1:0];
                    end
                    else
                    begin
                        res_next = sum[VB-1:0];
                    end
                    res_mon_next   = mon_reg;
                    res_mday_next  = mday_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            leap_reg      <= 1'b1;
            base1_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            leap_reg      <= leap_next;
            base1_reg     <= base1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        doy_reg      <= doy_next;
        mon_reg      <= mon_next;
        cum_reg      <= cum_next;
        cum_prev_reg <= cum_prev_next;
        mday_reg     <= mday_next;
        partner_reg  <= partner_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        res_mon_reg  <= res_mon_next;
        res_mday_reg <= res_mday_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[month_index] <= monthly_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    mdi_div #(
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DW-1:0]),
        .divisor  (n_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign out_valid    = out_valid_reg;
    assign daily_value  = res_reg;
    assign month_of_day = res_mon_reg;
    assign day_of_month = res_mday_reg;

    // The calendar walk never runs past December.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) && (mon_reg == LAST_MONTH) |=> (state_reg == ST_RD_CUR))
    else $error("calendar walk continued beyond December");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
    else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (kind == KIND_QUERY) |=> in_stall)
    else $error("query accepted without holding off the next item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_of_day <= LAST_MONTH) && (day_of_month != 6'd0)
                      && (day_of_month <= 6'd32))
    else $error("result month or day of month out of range");

endmodule
